/* sv/lsls_pkg.sv */
// ============================================================================
// lsls_pkg: shared types and constants for the light sensor lamp switch
// Register indexes, reset values, queue sizing and inter-module structs.
// ============================================================================
`default_nettype none

package lsls_pkg;

    // Samples per averaging group
    localparam int SAMPLES_DEF = 8;

    // Field widths
    localparam int SMP_W   = 12;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    // Queue between front and back
    localparam int QDEPTH  = 4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DARK_THRESHOLD = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HYSTERESIS     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DARK_WHEN_LOW  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MIN_ON_MS      = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MIN_OFF_MS     = 3'd4;

    // Configuration reset values
    localparam logic [SMP_W-1:0] RST_DARK_THRESHOLD = 12'd2048;
    localparam logic [SMP_W-1:0] RST_HYSTERESIS     = 12'd100;
    localparam logic             RST_DARK_WHEN_LOW  = 1'b0;
    localparam logic [MS_W-1:0]  RST_MIN_ON_MS      = 16'd1000;
    localparam logic [MS_W-1:0]  RST_MIN_OFF_MS     = 16'd1000;

    // Item classes handed from front to back
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_PART,
        KIND_GROUP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SMP_W-1:0]  avg;
    } t_qent;

    typedef struct packed {
        logic [SMP_W-1:0]  dark_threshold;
        logic [SMP_W-1:0]  hysteresis;
        logic              dark_when_low;
        logic [MS_W-1:0]   min_on_ms;
        logic [MS_W-1:0]   min_off_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/lsls_front.sv */
// ============================================================================
// lsls_front: input acceptance, group accumulation and averaging
// Classifies each transaction, sums samples per group and divides the
// completed sum by SAMPLES through a reciprocal multiply into the queue.
// ============================================================================
`default_nettype none

module lsls_front #(
    parameter int SAMPLES = lsls_pkg::SAMPLES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_op,
    input  wire logic [lsls_pkg::SMP_W-1:0] i_sample,
    output logic                           o_q_wr,
    output lsls_pkg::t_qent                o_q_ent,
    input  wire logic                      i_q_full
);

    localparam int LG   = (SAMPLES > 1) ? $clog2(SAMPLES) : 0;
    localparam int CW   = (LG > 0) ? LG : 1;
    localparam int SW   = lsls_pkg::SMP_W + LG;
    // reciprocal exact for every sum below 2^SW
    localparam int K    = SW + LG;
    localparam int MW   = SW + 1;
    localparam int PW   = SW + MW;
    localparam longint unsigned MUL = ((64'd1 << K) + SAMPLES - 1) / SAMPLES;
    localparam logic [MW-1:0] RECIP = MW'(MUL);
    localparam logic [CW-1:0] LAST  = CW'(SAMPLES - 1);

    logic [SW-1:0]   r_sum,   n_sum;
    logic [CW-1:0]   r_count, n_count;
    logic            r_s1_valid, n_s1_valid;
    lsls_pkg::t_kind r_s1_kind,  n_s1_kind;
    logic [SW-1:0]   r_s1_sum,   n_s1_sum;

    logic            w_accept;
    logic            w_drain;
    logic [SW-1:0]   w_sum;
    logic            w_last;
    logic [PW-1:0]   w_prod;

    // handshake
    assign w_drain  = r_s1_valid && !i_q_full;
    assign o_stall  = r_s1_valid && i_q_full;
    assign w_accept = i_valid && !o_stall;

    assign w_sum  = r_sum + SW'(i_sample);
    assign w_last = (r_count == LAST);

    // accumulate and classify
    always_comb begin
        n_sum      = r_sum;
        n_count    = r_count;
        n_s1_valid = r_s1_valid && !w_drain;
        n_s1_kind  = r_s1_kind;
        n_s1_sum   = r_s1_sum;
        if (w_accept) begin
            n_s1_valid = 1'b1;
            n_s1_sum   = w_sum;
            if (!i_op) begin
                n_s1_kind = lsls_pkg::KIND_TICK;
            end else if (w_last) begin
                n_s1_kind = lsls_pkg::KIND_GROUP;
                n_sum     = '0;
                n_count   = '0;
            end else begin
                n_s1_kind = lsls_pkg::KIND_PART;
                n_sum     = w_sum;
                n_count   = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_count    <= n_count;
            r_s1_valid <= n_s1_valid;
        end
        r_s1_kind <= n_s1_kind;
        r_s1_sum  <= n_s1_sum;
    end

    // divide by SAMPLES: multiply by reciprocal, keep the quotient bits
    assign w_prod = PW'(r_s1_sum) * PW'(RECIP);

    assign o_q_wr       = w_drain;
    assign o_q_ent.kind = r_s1_kind;
    assign o_q_ent.avg  = (r_s1_kind == lsls_pkg::KIND_GROUP) ?
                          w_prod[K +: lsls_pkg::SMP_W] : '0;

endmodule

`default_nettype wire

/* sv/lsls_queue.sv */
// ============================================================================
// lsls_queue: small FIFO between front and back
// Register-based queue; head entry visible while not empty.
// ============================================================================
`default_nettype none

module lsls_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire lsls_pkg::t_qent i_ent,
    output logic                 o_full,
    input  wire logic            i_rd,
    output logic                 o_empty,
    output lsls_pkg::t_qent      o_head
);

    localparam int PTR_W = $clog2(lsls_pkg::QDEPTH);
    localparam int CNT_W = $clog2(lsls_pkg::QDEPTH + 1);

    lsls_pkg::t_qent  r_mem [lsls_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(lsls_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_head  = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr = w_wr ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr = w_rd ? r_rptr + PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

endmodule

`default_nettype wire

/* sv/lsls_back.sv */
// ============================================================================
// lsls_back: lamp decision, dwell timer and result register
// Pops queued items, runs the hysteresis compare and minimum dwell check,
// keeps the millisecond counter and holds the result for the output side.
// ============================================================================
`default_nettype none

module lsls_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lsls_pkg::t_cfg             i_cfg,
    input  wire logic                       i_q_empty,
    input  wire lsls_pkg::t_qent            i_q_head,
    output logic                            o_q_rd,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_lamp_on,
    output logic                            o_changed,
    output logic                            o_decided,
    output logic [lsls_pkg::SMP_W-1:0]      o_average
);

    localparam int WW = lsls_pkg::SMP_W + 1;

    logic                       r_lamp,  n_lamp;
    logic [lsls_pkg::MS_W-1:0]  r_since, n_since;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_lamp,  n_out_lamp;
    logic                       r_out_chg,   n_out_chg;
    logic                       r_out_dec,   n_out_dec;
    logic [lsls_pkg::SMP_W-1:0] r_out_avg,   n_out_avg;

    logic          w_pop;
    logic [WW-1:0] w_avg, w_thr, w_hys;
    logic          w_want;
    logic          w_hold;
    logic          w_change;

    assign w_pop  = !i_q_empty && (!r_out_valid || !i_stall);
    assign o_q_rd = w_pop;

    // hysteresis compare at full precision
    assign w_avg = WW'(i_q_head.avg);
    assign w_thr = WW'(i_cfg.dark_threshold);
    assign w_hys = WW'(i_cfg.hysteresis);

    always_comb begin
        if (i_cfg.dark_when_low) begin
            w_want = r_lamp ? (w_avg <= w_thr + w_hys) : (w_avg <= w_thr);
        end else begin
            w_want = r_lamp ? (w_avg + w_hys >= w_thr) : (w_avg >= w_thr);
        end
    end

    // minimum dwell
    assign w_hold   = r_lamp ? (r_since < i_cfg.min_on_ms) : (r_since < i_cfg.min_off_ms);
    assign w_change = (w_want != r_lamp) && !w_hold;

    // state and result update
    always_comb begin
        n_lamp      = r_lamp;
        n_since     = r_since;
        n_out_valid = r_out_valid && i_stall;
        n_out_lamp  = r_out_lamp;
        n_out_chg   = r_out_chg;
        n_out_dec   = r_out_dec;
        n_out_avg   = r_out_avg;
        if (w_pop) begin
            n_out_valid = 1'b1;
            n_out_chg   = 1'b0;
            n_out_dec   = 1'b0;
            n_out_avg   = '0;
            unique case (i_q_head.kind)
                lsls_pkg::KIND_TICK: begin
                    if (r_since != '1) begin
                        n_since = r_since + lsls_pkg::MS_W'(1);
                    end
                end
                lsls_pkg::KIND_PART: begin
                end
                lsls_pkg::KIND_GROUP: begin
                    n_out_dec = 1'b1;
                    n_out_avg = i_q_head.avg;
                    if (w_change) begin
                        n_lamp    = !r_lamp;
                        n_since   = '0;
                        n_out_chg = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_out_lamp = n_lamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp      <= 1'b0;
            r_since     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lamp      <= n_lamp;
            r_since     <= n_since;
            r_out_valid <= n_out_valid;
        end
        r_out_lamp <= n_out_lamp;
        r_out_chg  <= n_out_chg;
        r_out_dec  <= n_out_dec;
        r_out_avg  <= n_out_avg;
    end

    assign o_valid   = r_out_valid;
    assign o_lamp_on = r_out_lamp;
    assign o_changed = r_out_chg;
    assign o_decided = r_out_dec;
    assign o_average = r_out_avg;

endmodule

`default_nettype wire

/* sv/light_sensor_lamp_switch.sv */
// ============================================================================
// light_sensor_lamp_switch: hysteresis lamp switch with minimum dwell time
// Path: accumulate stage, queue and result register, each registered; a
// stall on the output channel can hold items in the queue and accumulate
// stage. Throughput: one transaction per cycle while neither channel is
// stalled, set by the combinational accumulate and decision paths.
// Reset: synchronous active low; lamp off, counters and sums cleared,
// configuration registers return to their defaults.
// ============================================================================
`default_nettype none

module light_sensor_lamp_switch #(
    parameter int SAMPLES = lsls_pkg::SAMPLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_wr,
    input  wire logic [lsls_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire logic [lsls_pkg::CFG_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_op,
    input  wire logic [lsls_pkg::SMP_W-1:0]  i_sample,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_lamp_on,
    output logic                             o_changed,
    output logic                             o_decided,
    output logic [lsls_pkg::SMP_W-1:0]       o_average
);

    lsls_pkg::t_cfg  r_cfg, n_cfg;
    lsls_pkg::t_qent w_q_in, w_q_head;
    logic            w_q_wr, w_q_full, w_q_rd, w_q_empty;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                lsls_pkg::CFG_DARK_THRESHOLD:
                    n_cfg.dark_threshold = i_cfg_data[lsls_pkg::SMP_W-1:0];
                lsls_pkg::CFG_HYSTERESIS:
                    n_cfg.hysteresis = i_cfg_data[lsls_pkg::SMP_W-1:0];
                lsls_pkg::CFG_DARK_WHEN_LOW:
                    n_cfg.dark_when_low = i_cfg_data[0];
                lsls_pkg::CFG_MIN_ON_MS:
                    n_cfg.min_on_ms = i_cfg_data[lsls_pkg::MS_W-1:0];
                lsls_pkg::CFG_MIN_OFF_MS:
                    n_cfg.min_off_ms = i_cfg_data[lsls_pkg::MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold <= lsls_pkg::RST_DARK_THRESHOLD;
            r_cfg.hysteresis     <= lsls_pkg::RST_HYSTERESIS;
            r_cfg.dark_when_low  <= lsls_pkg::RST_DARK_WHEN_LOW;
            r_cfg.min_on_ms      <= lsls_pkg::RST_MIN_ON_MS;
            r_cfg.min_off_ms     <= lsls_pkg::RST_MIN_OFF_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: accept, accumulate, average
    lsls_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_op),
        .i_sample (i_sample),
        .o_q_wr   (w_q_wr),
        .o_q_ent  (w_q_in),
        .i_q_full (w_q_full)
    );

    // decoupling queue
    lsls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_ent   (w_q_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // back: decision and result
    lsls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_head  (w_q_head),
        .o_q_rd    (w_q_rd),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_lamp_on (o_lamp_on),
        .o_changed (o_changed),
        .o_decided (o_decided),
        .o_average (o_average)
    );

endmodule

`default_nettype wire
